// ===== src/afk_pkg.sv =====
package afk_pkg;

	localparam int ANGLE_BITS_DEF  = 16;
	localparam int LENGTH_BITS_DEF = 17;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_LINK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LINK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THIRD_LINK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOOL_ALONG  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TOOL_ACROSS = 3'd4;

	localparam int RESET_BASE_LINK   = 76500;
	localparam int RESET_SECOND_LINK = 70600;
	localparam int RESET_THIRD_LINK  = 90600;
	localparam int RESET_TOOL_ALONG  = 29100;
	localparam int RESET_TOOL_ACROSS = 45800;

	// pi in Q30, split into two 16-bit halves (0xC90FDAA2)
	localparam logic [15:0] PI_Q30_HI = 16'hC90F;
	localparam logic [15:0] PI_Q30_LO = 16'hDAA2;

	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [29:0] HALF_OCT = 30'h2000_0000;

	localparam int TAYLOR_STEPS = 5;
	localparam int unsigned SIN_DIV [TAYLOR_STEPS] = '{6, 20, 42, 72, 110};
	localparam int unsigned COS_DIV [TAYLOR_STEPS] = '{2, 12, 30, 56, 90};

	// phase front 4, Taylor cells 3 each, octant fold 1
	localparam int SINCOS_LAT = 4 + 3 * TAYLOR_STEPS + 1;

	localparam int OUT_MAX = 524287;
	localparam int OUT_MIN = -524288;

	typedef struct packed {
		logic signed [15:0] yaw_angle;
		logic signed [15:0] shoulder_angle;
		logic signed [15:0] elbow_angle;
		logic signed [15:0] wrist_angle;
	} afk_joints_t;

	typedef struct packed {
		logic signed [19:0] reach;
		logic signed [15:0] heading;
		logic signed [19:0] height;
	} afk_pose_t;

	// state handed from one Taylor cell to the next
	typedef struct packed {
		logic [2:0]         oct;
		logic [29:0]        x2;
		logic [30:0]        ts;
		logic [30:0]        tc;
		logic signed [31:0] s;
		logic signed [31:0] c;
	} afk_term_t;

endpackage

// ===== src/afk_phase.sv =====
module afk_phase #(
	parameter int ANGLE_BITS = afk_pkg::ANGLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	input  logic [ANGLE_BITS-1:0] angle,
	output logic                  term_valid,
	output afk_pkg::afk_term_t    term
);
	import afk_pkg::*;

	logic [31:0] phase;
	logic [2:0]  oct;
	logic [28:0] frac;
	logic [29:0] t;

	logic [45:0] hi_s1, lo_s1;
	logic [2:0]  oct_s1, oct_s2, oct_s3;
	logic [29:0] x_s2, x_s3;
	logic [59:0] sq_s3;
	logic [61:0] full;
	logic [60:0] sq_rnd;
	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	afk_term_t   term_s4;

	always_comb begin
		phase = 32'(angle) << (32 - ANGLE_BITS);
		oct   = phase[31:29];
		frac  = phase[28:0];
		t     = oct[0] ? (HALF_OCT - 30'(frac)) : 30'(frac);
		full  = {hi_s1, 16'b0} + 62'(lo_s1);
		sq_rnd = 61'(sq_s3) + 61'(HALF_OCT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		hi_s1  <= 46'(t) * 46'(PI_Q30_HI);
		lo_s1  <= 46'(t) * 46'(PI_Q30_LO);
		oct_s1 <= oct;
		// x = t * pi / 2^31, below 2^30
		x_s2   <= full[60:31];
		oct_s2 <= oct_s1;
		sq_s3  <= 60'(x_s2) * 60'(x_s2);
		x_s3   <= x_s2;
		oct_s3 <= oct_s2;
		term_s4.oct <= oct_s3;
		term_s4.x2  <= sq_rnd[59:30];
		term_s4.ts  <= {1'b0, x_s3};
		term_s4.tc  <= ONE_Q30;
		term_s4.s   <= $signed({2'b0, x_s3});
		term_s4.c   <= $signed({1'b0, ONE_Q30});
	end

	assign term_valid = valid_s4;
	assign term       = term_s4;

endmodule

// ===== src/afk_taylor_cell.sv =====
module afk_taylor_cell #(
	parameter int unsigned DIV_S = 6,
	parameter int unsigned DIV_C = 2,
	parameter bit          SUB   = 1'b1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	input  afk_pkg::afk_term_t term,
	output logic               next_valid,
	output afk_pkg::afk_term_t next_term
);
	import afk_pkg::*;

	// floor(2^32 / k): estimate is exact or one short for 30-bit dividends
	localparam logic [31:0] RECIP_S = 32'((64'd1 << 32) / DIV_S);
	localparam logic [31:0] RECIP_C = 32'((64'd1 << 32) / DIV_C);

	logic [60:0] prod_s, prod_c;
	logic [61:0] qprod_s, qprod_c;
	logic [29:0] ps_s1, pc_s1, ps_s2, pc_s2, qs_s2, qc_s2;
	logic [31:0] rem_s, rem_c;
	logic [29:0] qs_fix, qc_fix;
	afk_term_t   d_s1, d_s2, term_s3;
	logic        valid_s1, valid_s2, valid_s3;

	always_comb begin
		prod_s  = 61'(term.ts) * 61'(term.x2);
		prod_c  = 61'(term.tc) * 61'(term.x2);
		qprod_s = 62'(ps_s1) * 62'(RECIP_S);
		qprod_c = 62'(pc_s1) * 62'(RECIP_C);
		rem_s   = 32'(ps_s2) - 32'(qs_s2) * 32'(DIV_S);
		rem_c   = 32'(pc_s2) - 32'(qc_s2) * 32'(DIV_C);
		qs_fix  = qs_s2 + 30'(rem_s >= 32'(DIV_S));
		qc_fix  = qc_s2 + 30'(rem_c >= 32'(DIV_C));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ps_s1 <= prod_s[59:30];
		pc_s1 <= prod_c[59:30];
		d_s1  <= term;
		qs_s2 <= qprod_s[61:32];
		qc_s2 <= qprod_c[61:32];
		ps_s2 <= ps_s1;
		pc_s2 <= pc_s1;
		d_s2  <= d_s1;
		term_s3.oct <= d_s2.oct;
		term_s3.x2  <= d_s2.x2;
		term_s3.ts  <= {1'b0, qs_fix};
		term_s3.tc  <= {1'b0, qc_fix};
		if (SUB) begin
			term_s3.s <= d_s2.s - $signed({2'b0, qs_fix});
			term_s3.c <= d_s2.c - $signed({2'b0, qc_fix});
		end else begin
			term_s3.s <= d_s2.s + $signed({2'b0, qs_fix});
			term_s3.c <= d_s2.c + $signed({2'b0, qc_fix});
		end
	end

	assign next_valid = valid_s3;
	assign next_term  = term_s3;

endmodule

// ===== src/afk_sincos.sv =====
module afk_sincos #(
	parameter int ANGLE_BITS = afk_pkg::ANGLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	input  logic [ANGLE_BITS-1:0] angle,
	output logic                  result_valid,
	output logic signed [31:0]    sine,
	output logic signed [31:0]    cosine
);
	import afk_pkg::*;

	afk_term_t          chain [TAYLOR_STEPS+1];
	logic [TAYLOR_STEPS:0] chain_valid;
	logic signed [31:0] ps, pc;
	logic signed [31:0] sine_s1, cosine_s1;
	logic               valid_s1;

	afk_phase #(.ANGLE_BITS(ANGLE_BITS)) u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid),
		.angle      (angle),
		.term_valid (chain_valid[0]),
		.term       (chain[0])
	);

	for (genvar i = 0; i < TAYLOR_STEPS; i++) begin : g_cell
		afk_taylor_cell #(
			.DIV_S (SIN_DIV[i]),
			.DIV_C (COS_DIV[i]),
			.SUB   ((i % 2) == 0)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.valid      (chain_valid[i]),
			.term       (chain[i]),
			.next_valid (chain_valid[i+1]),
			.next_term  (chain[i+1])
		);
	end

	// fold the first-octant result back to the full turn
	always_comb begin
		if (chain[TAYLOR_STEPS].oct[0]) begin
			ps = chain[TAYLOR_STEPS].c;
			pc = chain[TAYLOR_STEPS].s;
		end else begin
			ps = chain[TAYLOR_STEPS].s;
			pc = chain[TAYLOR_STEPS].c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= chain_valid[TAYLOR_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		unique case (chain[TAYLOR_STEPS].oct[2:1])
			2'b00: begin
				sine_s1   <= ps;
				cosine_s1 <= pc;
			end
			2'b01: begin
				sine_s1   <= pc;
				cosine_s1 <= -ps;
			end
			2'b10: begin
				sine_s1   <= -ps;
				cosine_s1 <= -pc;
			end
			2'b11: begin
				sine_s1   <= -pc;
				cosine_s1 <= ps;
			end
		endcase
	end

	assign result_valid = valid_s1;
	assign sine         = sine_s1;
	assign cosine       = cosine_s1;

endmodule

// ===== src/arm_forward_kinematics_core.sv =====
// Forward kinematics of a yaw base plus three planar joints.
// Input: pulse start with the joint angles on joints; a transaction is taken
// at every clock edge where start is high and busy is low. busy stays low, so
// a new transaction can be issued in every cycle.
// Output: one pose per input, on pose for a single cycle with done high, in
// input order. The receiver cannot hold results off and none is needed:
// the pipeline never stalls.
// Throughput is one item per clock; latency is set by the sine/cosine lanes
// (4 phase stages, five 3-stage Taylor cells, one octant fold) plus the
// angle register and four stages of length products, sums, rounding and
// saturation.
// Configuration: link lengths are written over cfg_valid/cfg_ready with
// cfg_index selecting the register; cfg_ready is always high. Write only
// while no transaction is in flight. Unknown indexes are ignored.
// Reset: arst_n clears the pipeline valid flags and loads the default link
// lengths; no result is produced for transactions in flight at reset.
module arm_forward_kinematics_core #(
	parameter int ANGLE_BITS  = afk_pkg::ANGLE_BITS_DEF,
	parameter int LENGTH_BITS = afk_pkg::LENGTH_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  afk_pkg::afk_joints_t            joints,
	output logic                            done,
	output afk_pkg::afk_pose_t              pose,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [afk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [LENGTH_BITS-1:0]          cfg_data
);
	import afk_pkg::*;

	localparam int LAT      = 1 + SINCOS_LAT + 4;
	localparam int HEAD_DLY = SINCOS_LAT + 3;
	localparam int PROD_W   = LENGTH_BITS + 33;
	localparam int SUM_W    = PROD_W + 3;
	localparam int RND_W    = SUM_W - 30;
	localparam int CMP_W    = (RND_W > 21) ? RND_W : 21;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << 29;
	localparam logic signed [CMP_W-1:0] SAT_MAX    = CMP_W'(OUT_MAX);
	localparam logic signed [CMP_W-1:0] SAT_MIN    = CMP_W'(OUT_MIN);

	logic [LENGTH_BITS-1:0] len_base_q, len_second_q, len_third_q, len_along_q, len_across_q;

	logic                  accept;
	logic [ANGLE_BITS-1:0] yaw_in, a1, a2, a3;
	logic [15:0]           heading_in;
	logic [ANGLE_BITS-1:0] a1_s1, a2_s1, a3_s1;
	logic [15:0]           heading_s1;
	logic [15:0]           head_q [HEAD_DLY];
	logic                  valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic               lane_valid;
	logic signed [31:0] sin1, cos1, sin2, cos2, sin3, cos3;

	logic signed [LENGTH_BITS:0] l2s, l3s, lxs, lzs;
	logic signed [PROD_W-1:0] mr1_s2, mr2_s2, mr3_s2, mr4_s2;
	logic signed [PROD_W-1:0] mz1_s2, mz2_s2, mz3_s2, mz4_s2;
	logic signed [SUM_W-1:0]  base_term;
	logic signed [SUM_W-1:0]  r_a_s3, r_b_s3, z_a_s3, z_b_s3;
	logic signed [PROD_W-1:0] r_c_s3;
	logic signed [SUM_W-1:0]  r_sum, z_sum;
	logic signed [CMP_W-1:0]  reach_s4, height_s4;
	afk_pose_t                pose_s5;

	function automatic logic signed [19:0] sat20(input logic signed [CMP_W-1:0] v);
		if (v > SAT_MAX) begin
			return 20'(OUT_MAX);
		end else if (v < SAT_MIN) begin
			return 20'(OUT_MIN);
		end else begin
			return 20'(v);
		end
	endfunction

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_base_q   <= LENGTH_BITS'(RESET_BASE_LINK);
			len_second_q <= LENGTH_BITS'(RESET_SECOND_LINK);
			len_third_q  <= LENGTH_BITS'(RESET_THIRD_LINK);
			len_along_q  <= LENGTH_BITS'(RESET_TOOL_ALONG);
			len_across_q <= LENGTH_BITS'(RESET_TOOL_ACROSS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BASE_LINK:   len_base_q   <= cfg_data;
				CFG_SECOND_LINK: len_second_q <= cfg_data;
				CFG_THIRD_LINK:  len_third_q  <= cfg_data;
				CFG_TOOL_ALONG:  len_along_q  <= cfg_data;
				CFG_TOOL_ACROSS: len_across_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// cumulative joint angles, wrapping modulo one turn
	always_comb begin
		yaw_in     = ANGLE_BITS'($unsigned(joints.yaw_angle));
		heading_in = 16'(yaw_in);
		a1 = ANGLE_BITS'($unsigned(joints.shoulder_angle));
		a2 = a1 + ANGLE_BITS'($unsigned(joints.elbow_angle));
		a3 = a2 + ANGLE_BITS'($unsigned(joints.wrist_angle));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= lane_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		a1_s1      <= a1;
		a2_s1      <= a2;
		a3_s1      <= a3;
		heading_s1 <= heading_in;
		head_q[0]  <= heading_s1;
		for (int k = 1; k < HEAD_DLY; k++) begin
			head_q[k] <= head_q[k-1];
		end
	end

	afk_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane1 (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid_s1),
		.angle        (a1_s1),
		.result_valid (lane_valid),
		.sine         (sin1),
		.cosine       (cos1)
	);

	afk_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane2 (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid_s1),
		.angle        (a2_s1),
		.result_valid (),
		.sine         (sin2),
		.cosine       (cos2)
	);

	afk_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_lane3 (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid_s1),
		.angle        (a3_s1),
		.result_valid (),
		.sine         (sin3),
		.cosine       (cos3)
	);

	always_comb begin
		l2s = $signed({1'b0, len_second_q});
		l3s = $signed({1'b0, len_third_q});
		lxs = $signed({1'b0, len_along_q});
		lzs = $signed({1'b0, len_across_q});
		base_term = SUM_W'($signed({1'b0, len_base_q, 30'b0}));
		r_sum = r_a_s3 + r_b_s3 - SUM_W'(r_c_s3) + ROUND_HALF;
		z_sum = z_a_s3 + z_b_s3 + ROUND_HALF;
	end

	always_ff @(posedge clk) begin
		mr1_s2 <= PROD_W'(l2s) * PROD_W'(cos1);
		mr2_s2 <= PROD_W'(l3s) * PROD_W'(cos2);
		mr3_s2 <= PROD_W'(lxs) * PROD_W'(cos3);
		mr4_s2 <= PROD_W'(lzs) * PROD_W'(sin3);
		mz1_s2 <= PROD_W'(l2s) * PROD_W'(sin1);
		mz2_s2 <= PROD_W'(l3s) * PROD_W'(sin2);
		mz3_s2 <= PROD_W'(lxs) * PROD_W'(sin3);
		mz4_s2 <= PROD_W'(lzs) * PROD_W'(cos3);

		r_a_s3 <= base_term + SUM_W'(mr1_s2);
		r_b_s3 <= SUM_W'(mr2_s2) + SUM_W'(mr3_s2);
		r_c_s3 <= mr4_s2;
		z_a_s3 <= SUM_W'(mz1_s2) + SUM_W'(mz2_s2);
		z_b_s3 <= SUM_W'(mz3_s2) + SUM_W'(mz4_s2);

		// round half up: floor of the biased sum over 2^30
		reach_s4  <= CMP_W'($signed(r_sum[SUM_W-1:30]));
		height_s4 <= CMP_W'($signed(z_sum[SUM_W-1:30]));

		pose_s5.reach   <= sat20(reach_s4);
		pose_s5.height  <= sat20(height_s4);
		pose_s5.heading <= head_q[HEAD_DLY-1];
	end

	assign done = valid_s5;
	assign pose = pose_s5;

`ifndef ASSERT_OFF
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("accepted transaction did not complete after fixed latency");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result strobe without matching transaction");

	a_heading_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pose.heading == $past(heading_in, LAT)))
		else $error("heading out of step with its transaction");
`endif

endmodule
